[sv/ble_rpa_resolver_core_defines.svh]
// ----------------------------------------------------------------------------
// rpa resolver assertion macros
// shared assertion helpers for the resolver rtl
// ----------------------------------------------------------------------------
`ifndef BLE_RPA_RESOLVER_CORE_DEFINES_SVH
`define BLE_RPA_RESOLVER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define RPA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define RPA_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define RPA_ASSERT(label, clk, rst, prop)
`define RPA_ASSERT_NR(label, clk, prop)
`endif
`endif

[sv/rpa_pkg.sv]
// ----------------------------------------------------------------------------
// rpa resolver package
// aes-128 tables and round helpers shared by the resolver modules
// ----------------------------------------------------------------------------
`default_nettype none
package rpa_pkg;
  localparam int NUM_ROUNDS = 10;
  localparam int ADDR_W     = 48;
  localparam int KEY_W      = 64;
  localparam int BLOCK_W    = 128;

  typedef enum logic {CFG_KEY_LOW = 1'b0, CFG_KEY_HIGH = 1'b1} cfg_index_t;

  typedef logic [7:0] byte_t;
  typedef byte_t [15:0] block_t;
  typedef logic [3:0] round_idx_t;

  function automatic byte_t sbox(input byte_t x);
    byte_t t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic byte_t xtime(input byte_t x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t rcon(input round_idx_t r);
    byte_t v;
    v = 8'h01;
    for (int k = 1; k < 10; k++) begin
      if (k < int'(r)) v = xtime(v);
    end
    return v;
  endfunction

  // one key expansion step, round r from the previous round key
  function automatic block_t next_key(input block_t k, input round_idx_t r);
    block_t n;
    byte_t  w [4];
    w[0] = sbox(k[13]) ^ rcon(r);
    w[1] = sbox(k[14]);
    w[2] = sbox(k[15]);
    w[3] = sbox(k[12]);
    for (int i = 0; i < 16; i++) begin
      if (i < 4) n[i] = k[i] ^ w[i];
      else n[i] = k[i] ^ n[i-4];
    end
    return n;
  endfunction

  // subbytes, shiftrows and optional mixcolumns
  function automatic block_t round_fn(input block_t s, input logic last);
    block_t t;
    block_t m;
    byte_t  al;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = sbox(s[r + 4*((c + r) % 4)]);
      end
    end
    m = t;
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        al = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
        m[4*c]   = t[4*c]   ^ al ^ xtime(t[4*c]   ^ t[4*c+1]);
        m[4*c+1] = t[4*c+1] ^ al ^ xtime(t[4*c+1] ^ t[4*c+2]);
        m[4*c+2] = t[4*c+2] ^ al ^ xtime(t[4*c+2] ^ t[4*c+3]);
        m[4*c+3] = t[4*c+3] ^ al ^ xtime(t[4*c+3] ^ t[4*c]);
      end
    end
    return m;
  endfunction
endpackage
`default_nettype wire

[sv/rpa_round.sv]
// ----------------------------------------------------------------------------
// rpa aes round stage
// one registered aes round with its own key schedule step
// ----------------------------------------------------------------------------
`default_nettype none
module rpa_round
  import rpa_pkg::*;
#(
  parameter round_idx_t ROUND = 4'd1
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire block_t      in_state,
  input  wire block_t      in_key,
  input  wire logic [23:0] in_hash,
  output logic             out_valid,
  output block_t           out_state,
  output block_t           out_key,
  output logic [23:0]      out_hash
);
  block_t key_next;
  assign key_next = next_key(in_key, ROUND);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_state <= round_fn(in_state, ROUND == round_idx_t'(NUM_ROUNDS)) ^ key_next;
    out_key   <= key_next;
    out_hash  <= in_hash;
  end
endmodule
`default_nettype wire

[sv/ble_rpa_resolver_core.sv]
// ----------------------------------------------------------------------------
// ble rpa resolver core
// checks resolvable private addresses against an identity key with aes-128
// ----------------------------------------------------------------------------
// usage:
//   write key_low (index 0) and key_high (index 1) through cfg_we, cfg_index
//   and cfg_data while no address is in flight.
//   drive an address on rpa_address with start high; busy is always low, so
//   a new beat is taken every cycle.
//   the answer appears on match with done high for one cycle, once the start
//   beat has passed the input register, ten round stages and the compare.
//   throughput is one address per cycle; each aes round is its own stage
//   with its own key expansion step.
//   reset clears the keys and the valid bits of all stages.
//   there is no output stall: the receiver must take each done beat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ble_rpa_resolver_core_defines.svh"
module ble_rpa_resolver_core
  import rpa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [ADDR_W-1:0] rpa_address,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [KEY_W-1:0]  cfg_data,
  output logic                   done,
  output logic                   match
);
  logic [KEY_W-1:0] key_low;
  logic [KEY_W-1:0] key_high;

  logic   v0;
  block_t s0;
  block_t k0;
  logic [23:0] h0;

  logic   vs [NUM_ROUNDS+1];
  block_t ss [NUM_ROUNDS+1];
  block_t ks [NUM_ROUNDS+1];
  logic [23:0] hs [NUM_ROUNDS+1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_LOW:  key_low  <= cfg_data;
        CFG_KEY_HIGH: key_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // initial add round key stage
  always_ff @(posedge clk) begin
    block_t pt;
    block_t kb;
    kb = block_t'({key_high, key_low});
    pt = '0;
    pt[13] = rpa_address[47:40];
    pt[14] = rpa_address[39:32];
    pt[15] = rpa_address[31:24];
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
    s0 <= pt ^ kb;
    k0 <= kb;
    h0 <= rpa_address[23:0];
  end

  assign vs[0] = v0;
  assign ss[0] = s0;
  assign ks[0] = k0;
  assign hs[0] = h0;

  for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_round
    rpa_round #(.ROUND(round_idx_t'(g))) u_round (
      .clk      (clk),
      .rst      (rst),
      .in_valid (vs[g-1]),
      .in_state (ss[g-1]),
      .in_key   (ks[g-1]),
      .in_hash  (hs[g-1]),
      .out_valid(vs[g]),
      .out_state(ss[g]),
      .out_key  (ks[g]),
      .out_hash (hs[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vs[NUM_ROUNDS];
    end
    match <= (ss[NUM_ROUNDS][15] == hs[NUM_ROUNDS][7:0])
          && (ss[NUM_ROUNDS][14] == hs[NUM_ROUNDS][15:8])
          && (ss[NUM_ROUNDS][13] == hs[NUM_ROUNDS][23:16]);
  end

  `RPA_ASSERT(a_done_follows_last, clk, rst, vs[NUM_ROUNDS] |=> done)
  `RPA_ASSERT(a_first_stage, clk, rst, start |=> v0)
  `RPA_ASSERT(a_no_spurious, clk, rst, !vs[NUM_ROUNDS] |=> !done)
  `RPA_ASSERT_NR(a_never_busy, clk, !busy)
endmodule
`default_nettype wire
